### hdl/rau_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rau_pkg
// Shared widths, codes and controller/datapath types of the rational
// arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int FUNC_W        = 2;
	localparam int MAG_W         = 2 * OPERAND_WIDTH;
	localparam int NUM_W         = 2 * OPERAND_WIDTH + 1;
	localparam int DEN_W         = 2 * OPERAND_WIDTH - 1;
	localparam int CNT_W         = $clog2(MAG_W);

	localparam int IN_BITS       = FUNC_W + 4 * OPERAND_WIDTH;
	localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS      = NUM_W + DEN_W;
	localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

	localparam int FUNC_LSB      = 0;
	localparam int A_NUM_LSB     = FUNC_W;
	localparam int A_DEN_LSB     = A_NUM_LSB + OPERAND_WIDTH;
	localparam int B_NUM_LSB     = A_DEN_LSB + OPERAND_WIDTH;
	localparam int B_DEN_LSB     = B_NUM_LSB + OPERAND_WIDTH;
	localparam int RES_NUM_LSB   = 0;
	localparam int RES_DEN_LSB   = NUM_W;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MUL_P0,
		MUL_P1,
		MUL_D
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_GCD,
		DIV_QN,
		DIV_QD
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P0,
		ST_MUL_P1,
		ST_MUL_D,
		ST_FORM,
		ST_GCD_TEST,
		ST_GCD_RUN,
		ST_QN_RUN,
		ST_QD_START,
		ST_QD_RUN,
		ST_FINISH
	} rau_state_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     form;
		logic     div_start;
		logic     div_take;
		div_sel_t div_sel;
		logic     out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic in_err;
		logic y_zero;
		logic div_done;
		logic out_free;
	} rau_sts_t;

endpackage
`default_nettype wire

### hdl/rational_arithmetic_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the result reduced by its greatest common divisor.
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one request per transaction: func, a_num, a_den, b_num,
//   b_den. m_axis returns one reduced result per request, in order; tuser
//   flags a zero denominator or a division by zero (result then 0/0).
//   one request is worked on at a time: s_axis_tready is high only while
//   the unit is idle.
//   from acceptance to m_axis_tvalid the controller runs the multiply
//   states MUL_P0, MUL_P1 and MUL_D, a forming state, then from 1 to at
//   most 44 Euclid remainder steps (each a start state and a run of the
//   bit-serial divider), then the last test, the two quotient divisions
//   and the output load.
//   an erroneous request goes from MUL_P0 straight to the output load.
//   the next request can be taken in the cycle after the output load.
//   the result sits in an output register; the next request is taken while
//   it waits, and a finished result waits in the controller until the
//   output register is free, so a stalled receiver loses nothing.
//   reset clears the controller and the output valid; no other setup.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// func, a_num, a_den, b_num, b_den, zero pad
	input  wire logic [rau_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// result_num, result_den
	output logic      [rau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// error_code
	output logic                                 m_axis_tuser
);
	import rau_pkg::*;

	rau_cmd_t cmd;
	rau_sts_t sts;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rau_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.out_err   (m_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule
`default_nettype wire

### hdl/rau_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rau_div
// Iterative restoring divider, one quotient bit per cycle, giving quotient
// and remainder of two unsigned magnitudes.
// ---------------------------------------------------------------------------
module rau_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rau_pkg::MAG_W-1:0] dividend,
	input  wire logic [rau_pkg::MAG_W-1:0] divisor,
	output logic      [rau_pkg::MAG_W-1:0] quotient,
	output logic      [rau_pkg::MAG_W-1:0] remainder,
	output logic                           done
);
	import rau_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W:0]   rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dvs_q;
	logic [MAG_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[MAG_W-1:0], quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[MAG_W-1:0];
	assign done      = done_q;

endmodule
`default_nettype wire

### hdl/rau_dpath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rau_dpath
// Datapath: operand capture, shared multiplier, raw fraction forming,
// Euclid registers, divider and the output register.
// ---------------------------------------------------------------------------
module rau_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire rau_pkg::rau_cmd_t               cmd,
	output rau_pkg::rau_sts_t                    sts,
	input  wire logic [rau_pkg::IN_TDATA_W-1:0]  in_data,
	output logic      [rau_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                                 out_err,
	output logic                                 out_valid,
	input  wire logic                            out_ready
);
	import rau_pkg::*;

	func_t                         func_q;
	logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [MAG_W-1:0]       p0_q, p1_q, pd_q;
	logic signed [OPERAND_WIDTH-1:0] mx, my;
	logic signed [MAG_W-1:0]       prod;
	logic signed [NUM_W-1:0]       n_raw;
	logic [MAG_W-1:0]              mn, md;
	logic [MAG_W-1:0]              mn_q, md_q, x_q, y_q, qn_q, qd_q;
	logic                          neg_q;
	logic [MAG_W-1:0]              div_a, div_b, quo, rem;
	logic                          div_done;
	logic                          neg_eff;
	logic [NUM_W-1:0]              num_res;
	logic                          valid_q;
	logic [OUT_TDATA_W-1:0]        data_q;
	logic                          err_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_data[FUNC_LSB +: FUNC_W]);
			an_q   <= in_data[A_NUM_LSB +: OPERAND_WIDTH];
			ad_q   <= in_data[A_DEN_LSB +: OPERAND_WIDTH];
			bn_q   <= in_data[B_NUM_LSB +: OPERAND_WIDTH];
			bd_q   <= in_data[B_DEN_LSB +: OPERAND_WIDTH];
		end
	end

	assign sts.in_err = (ad_q == '0) || (bd_q == '0) || ((func_q == FUNC_DIV) && (bn_q == '0));

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_P0: begin
				mx = an_q;
				my = (func_q == FUNC_MUL) ? bn_q : bd_q;
			end
			MUL_P1: begin
				mx = bn_q;
				my = ad_q;
			end
			default: begin
				mx = ad_q;
				my = (func_q == FUNC_DIV) ? bn_q : bd_q;
			end
		endcase
	end

	assign prod = mx * my;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_P0:  p0_q <= prod;
				MUL_P1:  p1_q <= prod;
				default: pd_q <= prod;
			endcase
		end
	end

	always_comb begin
		case (func_q)
			FUNC_ADD: n_raw = NUM_W'(p0_q) + NUM_W'(p1_q);
			FUNC_SUB: n_raw = NUM_W'(p0_q) - NUM_W'(p1_q);
			default:  n_raw = NUM_W'(p0_q);
		endcase
	end

	assign mn = n_raw[NUM_W-1] ? MAG_W'(-n_raw) : MAG_W'(n_raw);
	assign md = pd_q[MAG_W-1] ? MAG_W'(-pd_q) : MAG_W'(pd_q);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_GCD: begin
				div_a = x_q;
				div_b = y_q;
			end
			DIV_QN: begin
				div_a = mn_q;
				div_b = x_q;
			end
			default: begin
				div_a = md_q;
				div_b = x_q;
			end
		endcase
	end

	rau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.quotient  (quo),
		.remainder (rem),
		.done      (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.form) begin
			mn_q  <= mn;
			md_q  <= md;
			x_q   <= mn;
			y_q   <= md;
			neg_q <= n_raw[NUM_W-1] ^ pd_q[MAG_W-1];
		end else if (cmd.div_take) begin
			unique case (cmd.div_sel)
				DIV_GCD: begin
					x_q <= y_q;
					y_q <= rem;
				end
				DIV_QN:  qn_q <= quo;
				default: qd_q <= quo;
			endcase
		end
	end

	assign sts.y_zero   = (y_q == '0);
	assign sts.div_done = div_done;
	assign sts.out_free = !valid_q || out_ready;

	assign neg_eff = neg_q && (qn_q != '0);
	assign num_res = neg_eff ? NUM_W'(-{1'b0, qn_q}) : NUM_W'(qn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (sts.in_err) begin
				data_q <= '0;
				err_q  <= 1'b1;
			end else begin
				data_q <= OUT_TDATA_W'({qd_q[DEN_W-1:0], num_res});
				err_q  <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_err   = err_q;

endmodule
`default_nettype wire

### hdl/rau_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences products, Euclid remainder steps and the two final
// divisions for one transaction at a time.
// ---------------------------------------------------------------------------
module rau_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_cmd_t      cmd
);
	import rau_pkg::*;

	rau_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_MUL_P0;
			ST_MUL_P0:   state_nxt = sts.in_err ? ST_FINISH : ST_MUL_P1;
			ST_MUL_P1:   state_nxt = ST_MUL_D;
			ST_MUL_D:    state_nxt = ST_FORM;
			ST_FORM:     state_nxt = ST_GCD_TEST;
			ST_GCD_TEST: state_nxt = sts.y_zero ? ST_QN_RUN : ST_GCD_RUN;
			ST_GCD_RUN:  if (sts.div_done) state_nxt = ST_GCD_TEST;
			ST_QN_RUN:   if (sts.div_done) state_nxt = ST_QD_START;
			ST_QD_START: state_nxt = ST_QD_RUN;
			ST_QD_RUN:   if (sts.div_done) state_nxt = ST_FINISH;
			ST_FINISH:   if (sts.out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = MUL_P0;
		cmd.div_sel = DIV_GCD;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL_P0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_P0;
			end
			ST_MUL_P1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_P1;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_D;
			end
			ST_FORM: cmd.form = 1'b1;
			ST_GCD_TEST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sts.y_zero ? DIV_QN : DIV_GCD;
			end
			ST_GCD_RUN: begin
				cmd.div_sel  = DIV_GCD;
				cmd.div_take = sts.div_done;
			end
			ST_QN_RUN: begin
				cmd.div_sel  = DIV_QN;
				cmd.div_take = sts.div_done;
			end
			ST_QD_START: begin
				cmd.div_sel   = DIV_QD;
				cmd.div_start = 1'b1;
			end
			ST_QD_RUN: begin
				cmd.div_sel  = DIV_QD;
				cmd.div_take = sts.div_done;
			end
			ST_FINISH: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### hdl/rau_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ---------------------------------------------------------------------------
module rau_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [rau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                            m_axis_tuser
);
	import rau_pkg::*;

	logic [NUM_W-1:0] res_num;
	logic [DEN_W-1:0] res_den;

	assign res_num = m_axis_tdata[RES_NUM_LSB +: NUM_W];
	assign res_den = m_axis_tdata[RES_DEN_LSB +: DEN_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result not zero");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> res_den != '0)
		else $error("zero denominator without error");

	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && res_num == '0 |-> res_den == DEN_W'(1))
		else $error("zero result not 0/1");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### sim/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for rational_arithmetic_unit. A table of directed
// requests (operand extremes, every func, zero denominators, division by a
// zero fraction, zero results) is followed by random requests in three
// flow-control phases. Every result is compared field by field, in order,
// against the table's expected value or an in-bench fraction reducer.
// ---------------------------------------------------------------------------
module tb_top;

	import rau_pkg::*;

	localparam int RANDOM_PER_PHASE = 484;
	localparam int QUIET_LIMIT      = 40000;
	localparam int DRAIN_CYCLES     = 64;
	localparam int NUM_DIRECTED     = 23;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic        [DEN_W-1:0] den;
		logic                    err;
	} fraction_t;

	typedef struct packed {
		func_t                          f;
		logic signed [OPERAND_WIDTH-1:0] an;
		logic signed [OPERAND_WIDTH-1:0] ad;
		logic signed [OPERAND_WIDTH-1:0] bn;
		logic signed [OPERAND_WIDTH-1:0] bd;
		logic                           typed;
		fraction_t                      want;
	} request_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	fraction_t    results_due[$];
	fraction_t    got_res;
	fraction_t    want_res;
	request_row_t directed_rows [NUM_DIRECTED];

	int src_idle_pct;
	int sink_idle_pct;
	int failures;
	int results_seen;
	int errors_seen;
	int quiet_cycles;
	int func_count [4];

	rational_arithmetic_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// multiply out, reduce by euclid gcd, positive denominator; error result for a zero denominator or division by zero
	function automatic fraction_t reduce_fraction(input func_t f,
			input logic signed [OPERAND_WIDTH-1:0] an, input logic signed [OPERAND_WIDTH-1:0] ad,
			input logic signed [OPERAND_WIDTH-1:0] bn, input logic signed [OPERAND_WIDTH-1:0] bd);
		longint          n;
		longint          d;
		longint unsigned mn;
		longint unsigned md;
		longint unsigned x;
		longint unsigned y;
		longint unsigned r;
		longint unsigned qn;
		longint unsigned qd;
		bit              neg;
		fraction_t       res;
		res = '{num: '0, den: '0, err: 1'b1};
		if (ad == 0 || bd == 0 || (f == FUNC_DIV && bn == 0))
			return res;
		case (f)
			FUNC_ADD: begin
				n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
				d = longint'(ad) * longint'(bd);
			end
			FUNC_SUB: begin
				n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
				d = longint'(ad) * longint'(bd);
			end
			FUNC_MUL: begin
				n = longint'(an) * longint'(bn);
				d = longint'(ad) * longint'(bd);
			end
			default: begin
				n = longint'(an) * longint'(bd);
				d = longint'(ad) * longint'(bn);
			end
		endcase
		mn = (n < 0) ? longint'(-n) : n;
		md = (d < 0) ? longint'(-d) : d;
		x = mn;
		y = md;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		qn = mn / x;
		qd = md / x;
		neg = (n < 0) != (d < 0);
		if (qn == 0)
			neg = 1'b0;
		res.num = neg ? NUM_W'(-qn) : NUM_W'(qn);
		res.den = DEN_W'(qd);
		res.err = 1'b0;
		return res;
	endfunction

	function automatic logic signed [OPERAND_WIDTH-1:0] draw_operand();
		logic signed [OPERAND_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = -16'sd1;
					3: v = 16'sd1;
					default: v = '0;
				endcase
			end
			1, 2: v = OPERAND_WIDTH'($urandom_range(0, 40) - 20);
			3: v = OPERAND_WIDTH'($urandom_range(0, 255) << $urandom_range(0, 8));
			default: v = OPERAND_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic issue_request(input request_row_t row);
		logic [IN_TDATA_W-1:0] word;
		word = '0;
		word[FUNC_LSB +: FUNC_W]         = row.f;
		word[A_NUM_LSB +: OPERAND_WIDTH] = row.an;
		word[A_DEN_LSB +: OPERAND_WIDTH] = row.ad;
		word[B_NUM_LSB +: OPERAND_WIDTH] = row.bn;
		word[B_DEN_LSB +: OPERAND_WIDTH] = row.bd;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(negedge clk);
			@(posedge clk);
		end
		results_due.push_back(row.typed ? row.want
			: reduce_fraction(row.f, row.an, row.ad, row.bn, row.bd));
		func_count[row.f]++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res.num = m_axis_tdata[RES_NUM_LSB +: NUM_W];
			got_res.den = m_axis_tdata[RES_DEN_LSB +: DEN_W];
			got_res.err = m_axis_tuser;
			results_seen++;
			if (got_res.err)
				errors_seen++;
			if (results_due.size() == 0) begin
				failures++;
				$display("%0t: unexpected result num=%0d den=%0d err=%0b", $time,
					got_res.num, got_res.den, got_res.err);
			end else begin
				want_res = results_due.pop_front();
				if (got_res.num !== want_res.num || got_res.den !== want_res.den ||
						got_res.err !== want_res.err) begin
					failures++;
					$display("%0t: mismatch expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
						$time, want_res.num, want_res.den, want_res.err,
						got_res.num, got_res.den, got_res.err);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, results_due.size());
			$display("FAIL rational_arithmetic_unit");
			$finish;
		end
	end

	initial begin
		request_row_t row;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		src_idle_pct  = 15;
		sink_idle_pct = 77;
		failures      = 0;
		results_seen  = 0;
		errors_seen   = 0;
		quiet_cycles  = 0;
		func_count    = '{0, 0, 0, 0};

		directed_rows = '{
			'{FUNC_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b0, '{33'sd0, 31'd0, 1'b0}},
			// zero results
			'{FUNC_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			'{FUNC_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			'{FUNC_MUL, 16'sd0, -16'sd3, 16'sd5, 16'sd7, 1'b1, '{33'sd0, 31'd1, 1'b0}},
			// zero denominators and division by zero, then a plain division
			'{FUNC_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 1'b1, '{33'sd0, 31'd0, 1'b1}},
			'{FUNC_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 1'b1, '{33'sd0, 31'd0, 1'b1}},
			'{FUNC_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 31'd0, 1'b1}},
			'{FUNC_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5, 1'b1, '{33'sd0, 31'd0, 1'b1}},
			'{FUNC_DIV, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 1'b1, '{33'sd0, 31'd0, 1'b1}},
			'{FUNC_DIV, 16'sd3, 16'sd4, 16'sd3, 16'sd4, 1'b1, '{33'sd1, 31'd1, 1'b0}},
			// operand extremes, sign cases and reductions
			'{FUNC_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 1'b1,
				'{33'sd1073741824, 31'd1, 1'b0}},
			'{FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
				'{33'sd2, 31'd1, 1'b0}},
			'{FUNC_SUB, 16'sh7fff, 16'sd1, 16'sh8000, 16'sd1, 1'b1, '{33'sd65535, 31'd1, 1'b0}},
			'{FUNC_ADD, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1, 1'b1, '{-33'sd65536, 31'd1, 1'b0}},
			'{FUNC_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, '{33'sd0, 31'd0, 1'b0}},
			'{FUNC_DIV, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, '{33'sd0, 31'd0, 1'b0}},
			'{FUNC_DIV, -16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b1, '{-33'sd1, 31'd1, 1'b0}},
			'{FUNC_MUL, -16'sd1, 16'sd2, 16'sd1, -16'sd2, 1'b1, '{33'sd1, 31'd4, 1'b0}},
			'{FUNC_ADD, 16'sh7fff, -16'sd1, 16'sh7fff, -16'sd1, 1'b1,
				'{-33'sd65534, 31'd1, 1'b0}},
			'{FUNC_SUB, 16'sd1, 16'sd3, 16'sd1, 16'sd2, 1'b0, '{33'sd0, 31'd0, 1'b0}},
			'{FUNC_ADD, 16'sd12345, 16'sh8000, -16'sd1, 16'sh7fff, 1'b0, '{33'sd0, 31'd0, 1'b0}},
			'{FUNC_DIV, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b1, '{33'sd1, 31'd1, 1'b0}},
			'{FUNC_MUL, 16'sd6, 16'sd4, 16'sd10, 16'sd15, 1'b1, '{33'sd1, 31'd1, 1'b0}}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 15;
					sink_idle_pct = 77;
				end
				1: begin
					src_idle_pct  = 77;
					sink_idle_pct = 15;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				row.f     = func_t'($urandom_range(0, 3));
				row.an    = draw_operand();
				row.ad    = draw_operand();
				row.bn    = draw_operand();
				row.bd    = draw_operand();
				row.typed = 1'b0;
				row.want  = '0;
				issue_request(row);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (results_due.size() != 0) begin
			failures++;
			$display("%0t: %0d results never arrived", $time, results_due.size());
		end
		$display("requests: %0d add, %0d sub, %0d mul, %0d div under three flow-control mixes",
			func_count[FUNC_ADD], func_count[FUNC_SUB], func_count[FUNC_MUL],
			func_count[FUNC_DIV]);
		$display("results checked: %0d, of which %0d flagged as errors; %0d failures",
			results_seen, errors_seen, failures);
		if (failures == 0)
			$display("PASS rational_arithmetic_unit");
		else
			$display("FAIL rational_arithmetic_unit");
		$finish;
	end

endmodule
`default_nettype wire
